>>> rtl/length_sum_frame_receiver_defines.svh
// assertion macros for the length-sum frame receiver
// used by rtl files that carry concurrent checks; no other dependencies
`ifndef LENGTH_SUM_FRAME_RECEIVER_DEFINES_SVH
`define LENGTH_SUM_FRAME_RECEIVER_DEFINES_SVH

// check a property on every rising edge outside reset
`define LSFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property on every rising edge, reset included
`define LSFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lsfr_pkg.sv
// shared types and codes for the length-sum frame receiver
// no dependencies
`default_nettype none

package lsfr_pkg;

    // operation codes of an input word
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic CFG_IDX_TIMEOUT    = 1'b0;
    localparam logic CFG_IDX_UPDATE_CMD = 1'b1;

    localparam logic [15:0] IDLE_SATURATED  = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;
    localparam logic [7:0]  UPDATE_CMD_RESET = 8'd0;

    typedef enum logic [1:0] {
        ST_IN_PROGRESS = 2'd0,
        ST_GOOD_STD    = 2'd1,
        ST_GOOD_UPDATE = 2'd2,
        ST_CSUM_ERR    = 2'd3
    } t_frame_status;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]    echo_byte;
        logic [8:0]    byte_position;
        logic          restarted;
        logic          frame_end;
        t_frame_status frame_status;
        logic [7:0]    command_code;
        logic [7:0]    parameter_code;
    } t_out_word;

    typedef struct packed {
        logic [15:0] idle_timeout_ticks;
        logic [7:0]  update_command_code;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/length_sum_frame_receiver.sv
// length-prefixed frame receiver with an 8-bit additive checksum
// top level; depends on lsfr_pkg, lsfr_frame_core and the assertion macro header
//
// usage:
//   input channel (i_in_valid / o_in_stall / i_in_word) carries one word per
//   received byte or per idle tick; output channel (o_out_valid / i_out_stall /
//   o_out_word) returns one word per received byte, echoing it with its
//   position, restart flag and, on the checksum byte, the frame verdict.
//   ticks produce no output word.
//   path: an accepted byte passes the input register, then classification
//   into the output register, which drives the output word.
//   throughput: one word per cycle while no byte waits on a stalled output;
//   the frame state (cursor, sum, lengths) updates as the held word moves on.
//   stall: while the output word waits, a byte in the input register holds
//   and o_in_stall rises; ticks still pass through since they need no slot.
//   config (i_cfg_*) is written at once; idle only is the user's duty, not enforced.
//   reset: synchronous active low; clears both registers' valid flags, the
//   frame state, and saturates the idle counter so the first byte restarts.
`default_nettype none
`include "length_sum_frame_receiver_defines.svh"

module length_sum_frame_receiver #(
    parameter int MAX_FRAME = 512
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire lsfr_pkg::t_in_word  i_in_word,
    // output channel
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output lsfr_pkg::t_out_word      o_out_word,
    // configuration write port
    input  wire logic                i_cfg_we,
    input  wire logic                i_cfg_index,
    input  wire logic [15:0]         i_cfg_data
);
    import lsfr_pkg::*;

    // input register
    logic      r_in_valid;
    t_in_word  r_in_word;
    // output register
    logic      r_out_valid;
    t_out_word r_out_word;
    // configuration
    t_cfg      r_cfg;

    logic      in_accept;
    logic      proc_fire;
    logic      out_free;
    logic      fire_byte;
    t_out_word core_result;

    // output slot can take a new word when empty or being drained now
    assign out_free  = !r_out_valid || !i_out_stall;
    // ticks never need the output slot
    assign proc_fire = r_in_valid && ((r_in_word.operation == OP_TICK) || out_free);
    assign fire_byte = proc_fire && (r_in_word.operation == OP_BYTE);

    assign o_in_stall  = r_in_valid && !proc_fire;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    lsfr_frame_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (proc_fire),
        .i_word   (r_in_word),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // input register: refill whenever the held word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_word <= i_in_word;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_byte) begin
            r_out_word <= core_result;
        end
    end

    // configuration register decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_timeout_ticks  <= TIMEOUT_RESET;
            r_cfg.update_command_code <= UPDATE_CMD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDX_TIMEOUT:    r_cfg.idle_timeout_ticks  <= i_cfg_data;
                CFG_IDX_UPDATE_CMD: r_cfg.update_command_code <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // checks
    `LSFR_ASSERT(a_end_after_header, i_clk, i_rst_n, (o_out_valid && o_out_word.frame_end) |-> (o_out_word.byte_position >= 9'd2), "frame end before command position")
    `LSFR_ASSERT(a_status_matches_end, i_clk, i_rst_n, o_out_valid |-> (o_out_word.frame_end == (o_out_word.frame_status != ST_IN_PROGRESS)), "status disagrees with frame end")
    `LSFR_ASSERT(a_restart_at_zero, i_clk, i_rst_n, (o_out_valid && o_out_word.restarted) |-> (o_out_word.byte_position == 9'd0), "restart away from position zero")
    `LSFR_ASSERT(a_codes_only_at_end, i_clk, i_rst_n, (o_out_valid && !o_out_word.frame_end) |-> (o_out_word.command_code == 8'd0 && o_out_word.parameter_code == 8'd0), "codes shown mid frame")
    `LSFR_ASSERT(a_stall_needs_word, i_clk, i_rst_n, o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall), "input stalled without cause")

endmodule

`default_nettype wire

>>> rtl/lsfr_frame_core.sv
// frame state and per-byte classification for the length-sum frame receiver
// depends on lsfr_pkg
`default_nettype none

module lsfr_frame_core #(
    parameter int MAX_FRAME = 512
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire lsfr_pkg::t_in_word i_word,
    input  wire lsfr_pkg::t_cfg    i_cfg,
    output lsfr_pkg::t_out_word    o_result
);
    import lsfr_pkg::*;

    localparam int CW = $clog2(MAX_FRAME);

    logic [CW-1:0] r_cursor,      n_cursor;
    logic [15:0]   r_frame_len,   n_frame_len;
    logic [7:0]    r_length_low,  n_length_low;
    logic [7:0]    r_running_sum, n_running_sum;
    logic [15:0]   r_idle_count,  n_idle_count;
    logic [7:0]    r_saved_cmd,   n_saved_cmd;
    logic [7:0]    r_saved_par,   n_saved_par;

    logic          restart;
    logic [CW-1:0] pos;
    logic          frame_end;
    logic [7:0]    b;
    logic [7:0]    cmd_eff;
    logic [7:0]    par_eff;
    t_frame_status status;

    assign b       = i_word.rx_byte;
    assign restart = r_idle_count >= i_cfg.idle_timeout_ticks;
    assign pos     = restart ? '0 : r_cursor;
    // end test is only live from the command position on
    assign frame_end = (pos > CW'(1)) && (16'(pos) >= r_frame_len);
    assign cmd_eff   = (pos == CW'(2)) ? b : r_saved_cmd;
    assign par_eff   = (pos == CW'(3)) ? b : r_saved_par;

    always_comb begin
        if (r_running_sum != b) begin
            status = ST_CSUM_ERR;
        end else if (cmd_eff == i_cfg.update_command_code) begin
            status = ST_GOOD_UPDATE;
        end else begin
            status = ST_GOOD_STD;
        end
    end

    always_comb begin
        o_result.echo_byte      = b;
        o_result.byte_position  = 9'(pos);
        o_result.restarted      = restart;
        o_result.frame_end      = frame_end;
        o_result.frame_status   = frame_end ? status : ST_IN_PROGRESS;
        o_result.command_code   = frame_end ? cmd_eff : 8'd0;
        o_result.parameter_code = frame_end ? par_eff : 8'd0;
    end

    always_comb begin
        n_cursor      = r_cursor;
        n_frame_len   = r_frame_len;
        n_length_low  = r_length_low;
        n_running_sum = r_running_sum;
        n_idle_count  = r_idle_count;
        n_saved_cmd   = r_saved_cmd;
        n_saved_par   = r_saved_par;
        if (i_fire) begin
            if (i_word.operation == OP_TICK) begin
                if (r_idle_count != IDLE_SATURATED) begin
                    n_idle_count = r_idle_count + 16'd1;
                end
            end else begin
                n_idle_count = '0;
                case (pos)
                    CW'(0): begin
                        n_length_low = b;
                        n_saved_cmd  = '0;
                        n_saved_par  = '0;
                    end
                    CW'(1): n_frame_len = {b + 8'hFF, r_length_low};
                    CW'(2): n_saved_cmd = b;
                    CW'(3): n_saved_par = b;
                    default: ;
                endcase
                if (frame_end) begin
                    n_cursor = '0;
                end else begin
                    // sum restarts with the first byte of a frame
                    n_running_sum = (pos == CW'(0)) ? b : r_running_sum + b;
                    n_cursor = (pos == CW'(MAX_FRAME - 1)) ? '0 : pos + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor      <= '0;
            r_frame_len   <= '0;
            r_length_low  <= '0;
            r_running_sum <= '0;
            r_idle_count  <= IDLE_SATURATED;
            r_saved_cmd   <= '0;
            r_saved_par   <= '0;
        end else begin
            r_cursor      <= n_cursor;
            r_frame_len   <= n_frame_len;
            r_length_low  <= n_length_low;
            r_running_sum <= n_running_sum;
            r_idle_count  <= n_idle_count;
            r_saved_cmd   <= n_saved_cmd;
            r_saved_par   <= n_saved_par;
        end
    end

endmodule

`default_nettype wire

>>> bench/tb_length_sum_frame_receiver.sv
`timescale 1ns / 100ps
// self-checking bench for length_sum_frame_receiver: a directed stimulus table, then random
// frames, noise and idle ticks under several register settings; depends on lsfr_pkg and the rtl

module tb_length_sum_frame_receiver;
    import lsfr_pkg::*;

    localparam int MAX_FRAME      = 512;
    localparam int DRAIN_CYCLES   = 8;        // two-register pipeline plus margin
    localparam int CYCLE_LIMIT    = 1_000_000;

    // one row of the directed table; want is only used when fixed is set
    typedef struct {
        t_in_word  stim;
        int        reps;
        bit        fixed;
        t_out_word want;
    } t_stim_row;

    // one register setting with its idling mix and amount of random traffic
    typedef struct {
        logic [15:0] timeout;
        logic [7:0]  update_cmd;
        int          gap;
        int          stall;
        int          words;
        bit          overlong;
    } t_phase;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    t_in_word    in_word   = '0;
    logic        out_stall = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_IDX_TIMEOUT;
    logic [15:0] cfg_data  = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_word   out_word;

    // predictor copy of the registers and the frame state
    logic [15:0] cfg_timeout;
    logic [7:0]  cfg_update;
    int          rx_cursor;
    logic [15:0] frame_len;
    logic [7:0]  len_low;
    logic [7:0]  frame_sum;
    logic [15:0] idle_ticks;
    logic [7:0]  frame_cmd;
    logic [7:0]  frame_param;

    t_out_word   pending_echoes[$];
    t_out_word   echo_want;
    int          errors      = 0;
    int          words_sent  = 0;
    int          cycle_count = 0;
    int          gap_pct     = 0;
    int          stall_pct   = 0;

    // directed part, timeout 100 and update command 0 as after reset
    t_stim_row directed_rows[27] = '{
        // ticks on a saturated idle counter leave it pinned at its ceiling
        '{'{OP_TICK, 8'h00}, 3, 1'b0, '0},
        // first byte after reset restarts, since the idle counter comes up saturated
        '{'{OP_BYTE, 8'h05}, 1, 1'b1,
          '{8'h05, 9'd0, 1'b1, 1'b0, ST_IN_PROGRESS, 8'h00, 8'h00}},
        '{'{OP_BYTE, 8'h01}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h00}, 1, 1'b0, '0},     // command equal to the update code
        '{'{OP_BYTE, 8'hFF}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h80}, 1, 1'b0, '0},
        // sum wraps past 8 bits: 05+01+00+FF+80 = 185
        '{'{OP_BYTE, 8'h85}, 1, 1'b1,
          '{8'h85, 9'd5, 1'b0, 1'b1, ST_GOOD_UPDATE, 8'h00, 8'hFF}},
        // length zero: closes at position 2, the checksum doubles as command
        '{'{OP_BYTE, 8'h00}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h01}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h01}, 1, 1'b1,
          '{8'h01, 9'd2, 1'b0, 1'b1, ST_GOOD_STD, 8'h01, 8'h00}},
        // bad checksum
        '{'{OP_BYTE, 8'h04}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h01}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'hAA}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h55}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h00}, 1, 1'b1,
          '{8'h00, 9'd4, 1'b0, 1'b1, ST_CSUM_ERR, 8'hAA, 8'h55}},
        // all-ones length bytes, one tick short of the timeout in between
        '{'{OP_BYTE, 8'hFF}, 1, 1'b0, '0},
        '{'{OP_TICK, 8'hFF}, 99, 1'b0, '0},
        '{'{OP_BYTE, 8'hFF}, 1, 1'b0, '0},
        // exactly the timeout: next byte starts over mid-frame
        '{'{OP_TICK, 8'h00}, 100, 1'b0, '0},
        '{'{OP_BYTE, 8'h07}, 1, 1'b1,
          '{8'h07, 9'd0, 1'b1, 1'b0, ST_IN_PROGRESS, 8'h00, 8'h00}},
        '{'{OP_BYTE, 8'h01}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'hC3}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h3C}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'hFF}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h00}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h80}, 1, 1'b0, '0},
        '{'{OP_BYTE, 8'h86}, 1, 1'b0, '0}
    };

    t_phase phases[7] = '{
        '{16'd1,     8'hFF, 49, 0,  50, 1'b0},  // one-tick timeout, sender gaps
        '{16'd20,    8'h00, 0,  49, 50, 1'b0},  // receiver stalls
        '{16'd65535, 8'h5A, 28, 28, 50, 1'b0},  // longest timeout, both idle
        '{16'd100,   8'h81, 0,  0,  10, 1'b1},  // one frame that runs past the cursor wrap
        '{16'd7,     8'h3C, 49, 0,  40, 1'b0},
        '{16'd12,    8'hC3, 0,  49, 40, 1'b0},
        '{16'd0,     8'h33, 28, 28, 20, 1'b0}   // zero timeout: every byte restarts
    };

    length_sum_frame_receiver #(
        .MAX_FRAME(MAX_FRAME)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // receiver side: stall decided at each falling edge
    always @(negedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: no progress before the cycle limit", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    // predictor: frame state after reset
    task automatic frame_state_reset();
        cfg_timeout = TIMEOUT_RESET;
        cfg_update  = UPDATE_CMD_RESET;
        rx_cursor   = 0;
        frame_len   = '0;
        len_low     = '0;
        frame_sum   = '0;
        idle_ticks  = IDLE_SATURATED;
        frame_cmd   = '0;
        frame_param = '0;
    endtask

    // predictor: one accepted word; a byte queues its echo, a tick only ages the idle count
    task automatic frame_predict(input t_in_word w);
        t_out_word r;
        int        pos;
        logic      restart;
        if (w.operation == OP_TICK) begin
            if (idle_ticks != IDLE_SATURATED)
                idle_ticks++;
            return;
        end
        restart = (idle_ticks >= cfg_timeout);
        if (restart)
            rx_cursor = 0;
        idle_ticks = '0;
        if (rx_cursor >= MAX_FRAME)
            rx_cursor = 0;
        pos = rx_cursor;
        case (pos)
            0: begin
                len_low     = w.rx_byte;
                frame_sum   = '0;
                frame_cmd   = '0;
                frame_param = '0;
            end
            // high byte travels as value plus one
            1: frame_len = {w.rx_byte - 8'd1, len_low};
            2: frame_cmd = w.rx_byte;
            3: frame_param = w.rx_byte;
            default: ;
        endcase
        r = '0;
        r.echo_byte     = w.rx_byte;
        r.byte_position = pos[8:0];
        r.restarted     = restart;
        if (pos > 1 && pos >= int'(frame_len)) begin
            r.frame_end      = 1'b1;
            r.command_code   = frame_cmd;
            r.parameter_code = frame_param;
            if (frame_sum != w.rx_byte)
                r.frame_status = ST_CSUM_ERR;
            else if (frame_cmd == cfg_update)
                r.frame_status = ST_GOOD_UPDATE;
            else
                r.frame_status = ST_GOOD_STD;
            rx_cursor = 0;
        end else begin
            frame_sum = frame_sum + w.rx_byte;
            rx_cursor = (pos + 1 >= MAX_FRAME) ? 0 : pos + 1;
        end
        pending_echoes.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // every word handed over on the output is checked against the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_echoes.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual %h", $time, out_word);
            end else begin
                echo_want = pending_echoes.pop_front();
                check_field("echo_byte", echo_want.echo_byte, out_word.echo_byte);
                check_field("byte_position", echo_want.byte_position, out_word.byte_position);
                check_field("restarted", echo_want.restarted, out_word.restarted);
                check_field("frame_end", echo_want.frame_end, out_word.frame_end);
                check_field("frame_status", echo_want.frame_status, out_word.frame_status);
                check_field("command_code", echo_want.command_code, out_word.command_code);
                check_field("parameter_code", echo_want.parameter_code,
                            out_word.parameter_code);
            end
        end
    end

    // sender: optional gap cycles, then hold the word until the block takes it
    task automatic send_word(input t_in_word w);
        @(negedge clk);
        while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        frame_predict(w);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_word w;
        w.operation = OP_BYTE;
        w.rx_byte   = b;
        send_word(w);
    endtask

    // rx_byte is don't-care on a tick, so it carries random bits
    task automatic send_tick();
        t_in_word w;
        w.operation = OP_TICK;
        w.rx_byte   = 8'($urandom_range(255));
        send_word(w);
    endtask

    // lower valid and wait out every expected word plus the pipeline depth
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_echoes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_IDX_TIMEOUT)
            cfg_timeout = val;
        else
            cfg_update = val[7:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // one frame with random content; truncate cuts it short before the checksum
    task automatic send_frame(input bit truncate);
        int         len;
        int         last;
        int         cut;
        int         p;
        int         r;
        logic [7:0] b;
        logic [7:0] sum;
        // get back to position 0: a timeout's worth of ticks, or finish a nearly done frame
        if (rx_cursor != 0) begin
            if (cfg_timeout != 0 && cfg_timeout <= 300)
                repeat (cfg_timeout) send_tick();
            else if (rx_cursor >= 2 && int'(frame_len) - rx_cursor <= 20)
                while (rx_cursor != 0)
                    send_byte(8'($urandom_range(255)));
        end
        r = $urandom_range(99);
        if (r < 10)
            len = $urandom_range(2);
        else if (r < 90)
            len = $urandom_range(3, 16);
        else
            len = $urandom_range(17, 60);
        last = (len < 2) ? 2 : len;
        cut  = truncate ? $urandom_range(1, last) : last + 1;
        sum  = '0;
        for (p = 0; p < last && p < cut; p++) begin
            case (p)
                0: b = len[7:0];
                1: b = len[15:8] + 8'd1;
                2: b = ($urandom_range(99) < 40) ? cfg_update : 8'($urandom_range(255));
                default: b = 8'($urandom_range(255));
            endcase
            send_byte(b);
            sum = sum + b;
            // a few ticks inside the frame, short of the timeout
            if (cfg_timeout > 1 && $urandom_range(19) == 0)
                repeat ($urandom_range(1, (cfg_timeout > 4) ? 3 : int'(cfg_timeout) - 1))
                    send_tick();
        end
        if (cut > last) begin
            b = sum;
            if ($urandom_range(99) < 15)
                b = b ^ 8'($urandom_range(1, 255));
            send_byte(b);
        end
    endtask

    // ticks around the timeout edge, or a short random run
    task automatic tick_burst();
        int n;
        case ($urandom_range(2))
            0: n = $urandom_range(1, 40);
            1: n = (cfg_timeout <= 300) ? int'(cfg_timeout) : 40;
            default: n = (cfg_timeout >= 2 && cfg_timeout <= 301) ? int'(cfg_timeout) - 1 : 1;
        endcase
        repeat (n) send_tick();
    endtask

    task automatic random_traffic(input int n);
        int start;
        int pick;
        start = words_sent;
        while (words_sent - start < n) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_frame(1'b0);
            else if (pick < 80)
                tick_burst();
            else if (pick < 90)
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            else
                send_frame(1'b1);
        end
    endtask

    // declared length of 512 or more: the cursor wraps and the next byte is a new length low
    task automatic overlong_frame();
        // start from position 0 so the second byte lands as the length high byte
        if (rx_cursor != 0)
            repeat (cfg_timeout) send_tick();
        send_byte(8'($urandom_range(255)));
        send_byte(8'h03);
        repeat (MAX_FRAME + 16) send_byte(8'($urandom_range(255)));
    endtask

    initial begin
        frame_state_reset();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed table at reset settings, no idling
        foreach (directed_rows[i]) begin
            repeat (directed_rows[i].reps) send_word(directed_rows[i].stim);
            if (directed_rows[i].fixed)
                pending_echoes[pending_echoes.size() - 1] = directed_rows[i].want;
        end
        drain();

        foreach (phases[i]) begin
            write_reg(CFG_IDX_TIMEOUT, phases[i].timeout);
            write_reg(CFG_IDX_UPDATE_CMD, {8'h00, phases[i].update_cmd});
            gap_pct   = phases[i].gap;
            stall_pct = phases[i].stall;
            if (phases[i].overlong)
                overlong_frame();
            random_traffic(phases[i].words);
            drain();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
